// ===== sv/mbsp_pkg.sv =====
// shared constants, message type and decode helpers for the midi byte stream parser
`default_nettype none
package mbsp_pkg;

   localparam int BYTE_W = 8;
   localparam int DATA_W = 7;
   localparam int CHAN_W = 4;
   localparam int CNT_W  = 2;

   localparam logic [BYTE_W-1:0] ST_REALTIME_MIN = 8'hF8;
   localparam logic [BYTE_W-1:0] ST_SYSEX_START  = 8'hF0;
   localparam logic [BYTE_W-1:0] ST_SYSEX_END    = 8'hF7;
   localparam logic [BYTE_W-1:0] ST_SONG_POS     = 8'hF2;
   localparam logic [BYTE_W-1:0] ST_TIME_CODE    = 8'hF1;
   localparam logic [BYTE_W-1:0] ST_SONG_SEL     = 8'hF3;
   localparam logic [BYTE_W-1:0] ST_SYSTEM_MIN   = 8'hF0;
   localparam logic [BYTE_W-1:0] ST_COMMON_MIN   = 8'hF1;
   localparam logic [BYTE_W-1:0] ST_NONE         = 8'h00;

   localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
   localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
   localparam logic [3:0] HI_VOICE_MIN   = 4'h8;
   localparam logic [3:0] HI_VOICE_MAX   = 4'hE;

   typedef struct packed {
      logic [BYTE_W-1:0] msg_status;
      logic [BYTE_W-1:0] msg_kind;
      logic [CHAN_W-1:0] msg_channel;
      logic [DATA_W-1:0] first_data;
      logic [DATA_W-1:0] second_data;
   } msg_type;

   // data bytes a channel-voice status asks for
   function automatic logic [CNT_W-1:0] voice_need(input logic [BYTE_W-1:0] st);
      logic [3:0] hi;
      hi = st[7:4];
      if (hi == HI_PROG_CHANGE || hi == HI_CHAN_PRESS) begin
         voice_need = 2'd1;
      end else if (hi >= HI_VOICE_MIN && hi <= HI_VOICE_MAX) begin
         voice_need = 2'd2;
      end else begin
         voice_need = 2'd0;
      end
   endfunction

   // data bytes a system common status asks for
   function automatic logic [CNT_W-1:0] common_need(input logic [BYTE_W-1:0] st);
      if (st == ST_SONG_POS) begin
         common_need = 2'd2;
      end else if (st == ST_TIME_CODE || st == ST_SONG_SEL) begin
         common_need = 2'd1;
      end else begin
         common_need = 2'd0;
      end
   endfunction

   function automatic msg_type build_msg(input logic [BYTE_W-1:0] st,
                                         input logic [DATA_W-1:0] d0,
                                         input logic [DATA_W-1:0] d1);
      msg_type m;
      m.msg_status = st;
      if (st >= ST_SYSTEM_MIN) begin
         m.msg_kind    = st;
         m.msg_channel = '0;
      end else begin
         m.msg_kind    = {st[7:4], 4'h0};
         m.msg_channel = st[3:0];
      end
      m.first_data  = d0;
      m.second_data = d1;
      build_msg = m;
   endfunction

endpackage
`default_nettype wire

// ===== sv/mbsp_req_if.sv =====
// byte input channel interface
`default_nettype none
interface mbsp_req_if;
   logic                         valid;
   logic                         ready;
   logic [mbsp_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/mbsp_rsp_if.sv =====
// message output channel interface
`default_nettype none
interface mbsp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mbsp_pkg::BYTE_W-1:0]  msg_status;
   logic [mbsp_pkg::BYTE_W-1:0]  msg_kind;
   logic [mbsp_pkg::CHAN_W-1:0]  msg_channel;
   logic [mbsp_pkg::DATA_W-1:0]  first_data;
   logic [mbsp_pkg::DATA_W-1:0]  second_data;

   modport source (output valid, output msg_status, output msg_kind, output msg_channel,
                   output first_data, output second_data, input ready);
   modport sink   (input valid, input msg_status, input msg_kind, input msg_channel,
                   input first_data, input second_data, output ready);
endinterface
`default_nettype wire

// ===== sv/mbsp_in_stage.sv =====
// input register stage holding one received byte
`default_nettype none
module mbsp_in_stage (
   input  wire logic                        clock,
   input  wire logic                        reset,
   mbsp_req_if.sink                         req_if,
   input  wire logic                        advance,
   output      logic                        byte_valid,
   output      logic [mbsp_pkg::BYTE_W-1:0] byte_data
);
   import mbsp_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              take;

   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_if.rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;
endmodule
`default_nettype wire

// ===== sv/mbsp_parse.sv =====
// parser state and byte classification, one byte per cycle while advance is high
`default_nettype none
module mbsp_parse (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic [mbsp_pkg::BYTE_W-1:0] byte_data,
   output      logic                        emit,
   output      mbsp_pkg::msg_type           msg
);
   import mbsp_pkg::*;

   logic [BYTE_W-1:0] running_ff, running_in;
   logic [BYTE_W-1:0] current_ff, current_in;
   logic [CNT_W-1:0]  have_ff, have_in;
   logic [CNT_W-1:0]  need_ff, need_in;
   logic              sysex_ff, sysex_in;
   logic [DATA_W-1:0] hold0_ff, hold0_in;
   logic [DATA_W-1:0] hold1_ff, hold1_in;

   always_comb begin
      logic [BYTE_W-1:0] st;
      logic [CNT_W-1:0]  h;
      logic [CNT_W-1:0]  n;
      logic [CNT_W-1:0]  h_next;
      logic              go;
      logic [CNT_W-1:0]  cn;

      running_in = running_ff;
      current_in = current_ff;
      have_in    = have_ff;
      need_in    = need_ff;
      sysex_in   = sysex_ff;
      hold0_in   = hold0_ff;
      hold1_in   = hold1_ff;
      emit       = 1'b0;
      msg        = build_msg(ST_NONE, '0, '0);
      st         = current_ff;
      h          = have_ff;
      n          = need_ff;
      h_next     = '0;
      go         = 1'b1;
      cn         = common_need(byte_data);

      if (byte_data >= ST_REALTIME_MIN) begin
         // real-time passes straight out, state untouched
         emit = 1'b1;
         msg  = build_msg(byte_data, '0, '0);
      end else if (byte_data[7]) begin
         if (byte_data == ST_SYSEX_START || byte_data == ST_SYSEX_END) begin
            sysex_in   = (byte_data == ST_SYSEX_START);
            running_in = ST_NONE;
            current_in = ST_NONE;
         end else if (byte_data >= ST_COMMON_MIN) begin
            sysex_in   = 1'b0;
            running_in = ST_NONE;
            have_in    = '0;
            need_in    = cn;
            if (cn == '0) begin
               current_in = ST_NONE;
               emit       = 1'b1;
               msg        = build_msg(byte_data, hold0_ff, hold1_ff);
            end else begin
               current_in = byte_data;
            end
         end else begin
            sysex_in   = 1'b0;
            running_in = byte_data;
            current_in = byte_data;
            have_in    = '0;
            need_in    = voice_need(byte_data);
         end
      end else if (!sysex_ff) begin
         if (current_ff == ST_NONE) begin
            if (running_ff == ST_NONE) begin
               go = 1'b0;
            end else begin
               st = running_ff;
               h  = '0;
               n  = voice_need(running_ff);
            end
         end
         if (go) begin
            if (h[0]) begin
               hold1_in = byte_data[DATA_W-1:0];
            end else begin
               hold0_in = byte_data[DATA_W-1:0];
            end
            h_next     = h + 2'd1;
            current_in = st;
            need_in    = n;
            have_in    = h_next;
            if (h_next >= n) begin
               emit       = 1'b1;
               msg        = build_msg(st, hold0_in, hold1_in);
               have_in    = '0;
               current_in = (st >= ST_SYSTEM_MIN) ? ST_NONE : running_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= ST_NONE;
         current_ff <= ST_NONE;
         have_ff    <= '0;
         need_ff    <= '0;
         sysex_ff   <= 1'b0;
         hold0_ff   <= '0;
         hold1_ff   <= '0;
      end else if (advance) begin
         running_ff <= running_in;
         current_ff <= current_in;
         have_ff    <= have_in;
         need_ff    <= need_in;
         sysex_ff   <= sysex_in;
         hold0_ff   <= hold0_in;
         hold1_ff   <= hold1_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/mbsp_out_reg.sv =====
// result register driving the message channel
`default_nettype none
module mbsp_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire mbsp_pkg::msg_type msg,
   output      logic              free,
   mbsp_rsp_if.source             rsp_if
);
   import mbsp_pkg::*;

   logic    valid_ff, valid_in;
   msg_type msg_ff, msg_in;

   assign free = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff && !rsp_if.ready;
      msg_in   = msg_ff;
      if (load) begin
         valid_in = 1'b1;
         msg_in   = msg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      msg_ff <= msg_in;
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.msg_status  = msg_ff.msg_status;
   assign rsp_if.msg_kind    = msg_ff.msg_kind;
   assign rsp_if.msg_channel = msg_ff.msg_channel;
   assign rsp_if.first_data  = msg_ff.first_data;
   assign rsp_if.second_data = msg_ff.second_data;
endmodule
`default_nettype wire

// ===== sv/midi_byte_stream_parser_core.sv =====
// midi byte stream parser with running status, sysex filtering and real-time pass-through
// a word accepted into the input register reaches the result port through the result
// register, if it makes a message; the result register is loaded only when it has room
// throughput: one byte word per cycle while the result port keeps up; a message left waiting
// holds the registered byte, so the input takes at most one more word until it is taken
// reset (synchronous, active high) clears running status, sysex flag, counts, stored data
// and both stage valids; nothing is in flight afterwards
`default_nettype none
module midi_byte_stream_parser_core (
   input  wire logic  clock,
   input  wire logic  reset,
   mbsp_req_if.sink   req_if,
   mbsp_rsp_if.source rsp_if
);
   import mbsp_pkg::*;

   logic              byte_valid;
   logic [BYTE_W-1:0] byte_data;
   logic              out_free;
   logic              advance;
   logic              emit;
   msg_type           msg;

   // the registered byte moves on once the result register has room for it
   assign advance = byte_valid && out_free;

   // input register stage
   mbsp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   // classification and state update, committed only as the byte leaves the stage
   mbsp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .byte_data (byte_data),
      .emit      (emit),
      .msg       (msg)
   );

   // result register; while a finished message waits here the parser holds its byte
   mbsp_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && emit),
      .msg    (msg),
      .free   (out_free),
      .rsp_if (rsp_if)
   );
endmodule
`default_nettype wire

// ===== bench/midi_byte_stream_parser_core_tb.sv =====
// self-checking testbench for the midi byte stream parser: directed and random byte words
`default_nettype none
module midi_byte_stream_parser_core_tb;
   import mbsp_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 5;
   localparam int STALL_LIMIT  = 2000;   // cycles with no handshake at all before giving up
   localparam int TAIL_CYCLES  = 8;      // latency through both registers plus margin for stray messages
   localparam int RANDOM_WORDS = 1700;

   // status bytes used by the directed part that the package does not name
   localparam logic [7:0] ST_NOTE_ON_CH0 = 8'h90;
   localparam logic [7:0] ST_PROG_CH5    = 8'hC5;
   localparam logic [7:0] ST_PITCH_CH15  = 8'hEF;
   localparam logic [7:0] ST_UNDEF_F4    = 8'hF4;
   localparam logic [7:0] ST_RT_START    = 8'hFA;
   localparam logic [7:0] ST_RT_RESET    = 8'hFF;

   // scoreboard: tracks the parser state, predicts messages and checks them in order
   class midi_msg_scoreboard;
      logic [7:0] run_status;
      logic [7:0] open_st;
      logic [1:0] have_cnt;
      logic [1:0] need_cnt;
      bit         sysex_open;
      logic [6:0] held [2];
      msg_type    awaited_msgs [$];
      int unsigned mismatches;
      int unsigned checked;

      function new();
         run_status = ST_NONE;
         open_st    = ST_NONE;
         have_cnt   = '0;
         need_cnt   = '0;
         sysex_open = 1'b0;
         held[0]    = '0;
         held[1]    = '0;
         mismatches = 0;
         checked    = 0;
      endfunction

      // data bytes that follow a status byte
      function logic [1:0] data_count(input logic [7:0] st);
         if (st >= ST_REALTIME_MIN || st == ST_SYSEX_START || st == ST_SYSEX_END) return 2'd0;
         if (st == ST_SONG_POS) return 2'd2;
         if (st == ST_TIME_CODE || st == ST_SONG_SEL) return 2'd1;
         if (st >= ST_SYSTEM_MIN) return 2'd0;
         if (st[7:4] == HI_PROG_CHANGE || st[7:4] == HI_CHAN_PRESS) return 2'd1;
         return 2'd2;
      endfunction

      function void queue_msg(input logic [7:0] st, input logic [6:0] d0,
                              input logic [6:0] d1);
         msg_type m;
         m.msg_status = st;
         if (st >= ST_SYSTEM_MIN) begin
            m.msg_kind    = st;
            m.msg_channel = '0;
         end else begin
            m.msg_kind    = st & 8'hF0;
            m.msg_channel = st[3:0];
         end
         m.first_data  = d0;
         m.second_data = d1;
         awaited_msgs.push_back(m);
      endfunction

      // one accepted byte word
      function void note_byte(input logic [7:0] b);
         if (b >= ST_REALTIME_MIN) begin
            queue_msg(b, '0, '0);
            return;
         end
         if (b[7]) begin
            if (b == ST_SYSEX_START || b == ST_SYSEX_END) begin
               sysex_open = (b == ST_SYSEX_START);
               run_status = ST_NONE;
               open_st    = ST_NONE;
               return;
            end
            sysex_open = 1'b0;
            open_st    = b;
            have_cnt   = '0;
            need_cnt   = data_count(b);
            if (b >= ST_COMMON_MIN) begin
               run_status = ST_NONE;
               if (need_cnt == 2'd0) begin
                  open_st = ST_NONE;
                  queue_msg(b, held[0], held[1]);
               end
            end else begin
               run_status = b;
            end
            return;
         end
         if (sysex_open) return;
         if (open_st == ST_NONE) begin
            if (run_status == ST_NONE) return;
            open_st  = run_status;
            have_cnt = '0;
            need_cnt = data_count(run_status);
         end
         held[have_cnt[0]] = b[6:0];
         have_cnt = have_cnt + 2'd1;
         if (have_cnt >= need_cnt) begin
            queue_msg(open_st, held[0], held[1]);
            have_cnt = '0;
            open_st  = (open_st >= ST_SYSTEM_MIN) ? ST_NONE : run_status;
         end
      endfunction

      function void check_msg(input msg_type got);
         msg_type want;
         if (awaited_msgs.size() == 0) begin
            $error("message with status %h arrived with none awaited", got.msg_status);
            mismatches++;
            return;
         end
         want = awaited_msgs.pop_front();
         checked++;
         if (got.msg_status !== want.msg_status) begin
            $error("msg_status: expected %h, actual %h", want.msg_status, got.msg_status);
            mismatches++;
         end
         if (got.msg_kind !== want.msg_kind) begin
            $error("msg_kind: expected %h, actual %h", want.msg_kind, got.msg_kind);
            mismatches++;
         end
         if (got.msg_channel !== want.msg_channel) begin
            $error("msg_channel: expected %h, actual %h", want.msg_channel, got.msg_channel);
            mismatches++;
         end
         if (got.first_data !== want.first_data) begin
            $error("first_data: expected %h, actual %h", want.first_data, got.first_data);
            mismatches++;
         end
         if (got.second_data !== want.second_data) begin
            $error("second_data: expected %h, actual %h", want.second_data, got.second_data);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mbsp_req_if req ();
   mbsp_rsp_if rsp ();

   midi_byte_stream_parser_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   midi_msg_scoreboard sb;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned words_sent;

   // directed opening: real-time extremes, stray data, zero-data common, running status,
   // one-data voice, real-time inside a song position, sysex open and close, stray after
   // sysex, data extremes on pitch bend
   logic [7:0] directed_words [25] = '{
      ST_REALTIME_MIN, ST_RT_RESET, 8'h00, ST_UNDEF_F4,
      ST_NOTE_ON_CH0, 8'h3C, 8'h7F, 8'h40, 8'h00,
      ST_PROG_CH5, 8'h7F, 8'h23,
      ST_SONG_POS, 8'h01, ST_RT_START, 8'h7F,
      ST_TIME_CODE, 8'h55,
      ST_SYSEX_START, 8'h12, ST_SYSEX_END, 8'h45,
      ST_PITCH_CH15, 8'h7F, 8'h7F
   };

   // free-running clock, low first so that no edge falls at time zero
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // receiver: ready decided afresh at every falling edge
   always @(negedge clock) begin
      rsp.ready = ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // sampling at the rising edge: note accepted byte words, check accepted messages
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) sb.note_byte(req.rx_byte);
         if (rsp.valid && rsp.ready) begin
            sb.check_msg('{rsp.msg_status, rsp.msg_kind, rsp.msg_channel,
                           rsp.first_data, rsp.second_data});
         end
      end
   end

   // watchdog on handshake activity
   initial begin : watchdog
      int unsigned stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall = 0;
         else stall++;
      end
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [7:0] word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid   = 1'b1;
      req.rx_byte = word;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // data byte, sometimes with a real-time byte slipped in ahead of it
   task automatic send_data(inout int unsigned sent);
      if ($urandom_range(0, 9) == 0) begin
         send_word(8'($urandom_range(8'hF8, 8'hFF)));
         sent++;
      end
      send_word(8'($urandom_range(0, 127)));
      sent++;
   endtask

   // mostly well-formed messages with random content, plus sysex, real-time bytes, noise and cut-off messages
   task automatic send_random_traffic(input int unsigned n_words);
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      logic [7:0]  st;
      logic [7:0]  run_guess;
      sent      = 0;
      run_guess = ST_NONE;
      while (sent < n_words) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            // voice message, a quarter of them leaning on running status
            st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
            if (run_guess != ST_NONE && $urandom_range(0, 3) == 0) begin
               st = run_guess;
            end else begin
               send_word(st);
               sent++;
               run_guess = st;
            end
            len = sb.data_count(st);
            repeat (len) send_data(sent);
         end else if (pick < 62) begin
            // system common, ends running status
            st = 8'($urandom_range(8'hF1, 8'hF6));
            send_word(st);
            sent++;
            run_guess = ST_NONE;
            len = sb.data_count(st);
            repeat (len) send_data(sent);
         end else if (pick < 70) begin
            // sysex with a short payload; payload words do not count
            send_word(ST_SYSEX_START);
            sent++;
            run_guess = ST_NONE;
            len = $urandom_range(0, 6);
            repeat (len) send_word(8'($urandom_range(0, 127)));
            if ($urandom_range(0, 4) != 0) begin
               send_word(ST_SYSEX_END);
               sent++;
            end
         end else if (pick < 78) begin
            send_word(8'($urandom_range(8'hF8, 8'hFF)));
            sent++;
         end else if (pick < 88) begin
            // noise: any byte value at all
            st = 8'($urandom_range(0, 255));
            send_word(st);
            sent++;
            if (st[7] && st < ST_REALTIME_MIN) run_guess = ST_NONE;
         end else begin
            // message cut short by whatever comes next
            st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
            send_word(st);
            sent++;
            run_guess = st;
            len = $urandom_range(0, sb.data_count(st) - 1);
            repeat (len) send_data(sent);
         end
      end
      words_sent += sent;
   endtask

   initial begin
      sb            = new();
      req.valid     = 1'b0;
      req.rx_byte   = '0;
      rsp.ready     = 1'b0;
      words_sent    = 0;
      send_idle_pct = 11;
      recv_idle_pct = 84;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_words[i]) send_word(directed_words[i]);
      words_sent += $size(directed_words);

      // three idle patterns: slow receiver, slow sender, then flat out
      send_random_traffic(RANDOM_WORDS / 3);
      send_idle_pct = 84;
      recv_idle_pct = 11;
      send_random_traffic(RANDOM_WORDS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_traffic(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
      req.valid = 1'b0;

      // drain, then give any unexpected message time to show
      while (sb.awaited_msgs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d byte words over three idle patterns", words_sent);
      $display("%0d messages compared, %0d field mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/mbsp_pkg.sv
sv/mbsp_req_if.sv
sv/mbsp_rsp_if.sv
sv/mbsp_in_stage.sv
sv/mbsp_parse.sv
sv/mbsp_out_reg.sv
sv/midi_byte_stream_parser_core.sv
bench/midi_byte_stream_parser_core_tb.sv
